// File: rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg: shared constants and types for the LFU key-value store
// Holds the fixed port field widths, the capacity register reset value and
// the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

    localparam int VALUE_W     = 32;
    localparam int KEY_PORT_W  = 16;
    localparam int CAP_REG_W   = 5;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    localparam logic [CAP_REG_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_SCAN      = 7'b0000010,
        ST_DRAIN     = 7'b0000100,
        ST_DECIDE    = 7'b0001000,
        ST_UPDATE    = 7'b0010000,
        ST_UPD_DRAIN = 7'b0100000,
        ST_FINISH    = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

// File: rtl/lfu_ram.sv
// ----------------------------------------------------------------------------
// lfu_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/lfu_cache_lru_tiebreak_top.sv
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_top: LFU key-value store with LRU tie-break
// Fully associative store; entries live in one RAM and are scanned and then
// rewritten by a small sequencer.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake                     Contents
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser: func; tdata: key, write_value
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: hit, read_value, evicted,
//                                               evicted_key
//  cfg       in   cfg_we                        capacity
//
// A hit or a put of a new key runs two passes over the RAM: a lookup pass reads
// every RAM entry once, then a write-back pass rewrites the valid entries. A get
// miss skips the write-back pass. With capacity zero the sequencer goes from idle
// straight to the finish state and skips both passes. After each load the sequencer
// returns to idle, and a beat is taken only there. Valid bits are flip-flops, so no
// clearing pass follows reset. A stalled result waits in the output register while
// the next beat is already taken and processed.
`default_nettype none

module lfu_cache_lru_tiebreak_top #(
    parameter int CAP      = 16,
    parameter int FREQ_MAX = 255,
    parameter int KEY_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [15:0] key, [47:16] write_value
    input  wire logic [lfu_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] func
    input  wire logic                              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [0] hit, [32:1] read_value, [33] evicted, [49:34] evicted_key, rest zero
    output logic      [lfu_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [lfu_pkg::CAP_REG_W-1:0]     cfg_wdata
);

    import lfu_pkg::*;

    localparam int IDX_W  = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int RANK_W = IDX_W;
    localparam int OCC_W  = $clog2(CAP + 1);
    localparam int CNT_W  = $clog2(FREQ_MAX + 1);
    localparam int KEY_W  = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;

    localparam logic [CNT_W-1:0] FREQ_TOP = CNT_W'(FREQ_MAX);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAP - 1);

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [CNT_W-1:0]   cnt;
        logic [RANK_W-1:0]  rank;
    } entry_t;

    localparam int ENT_W = $bits(entry_t);

    state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic [CAP_REG_W-1:0] cap_reg;
    logic [OCC_W-1:0]     cap_eff;
    logic [OCC_W-1:0]     occ_reg;
    logic [CAP-1:0]       valid_reg, valid_next;

    logic             pend_reg;
    logic [IDX_W-1:0] pend_idx_reg;

    // Operation being worked on
    logic               op_put_reg;
    logic [KEY_W-1:0]   op_key_reg;
    logic [VALUE_W-1:0] op_value_reg;

    // Lookup pass results
    logic               hit_found_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [VALUE_W-1:0] hit_value_reg;
    logic [RANK_W-1:0]  hit_rank_reg;
    logic               vic_found_reg;
    logic [IDX_W-1:0]   vic_idx_reg;
    logic [KEY_W-1:0]   vic_key_reg;
    logic [CNT_W-1:0]   vic_cnt_reg;
    logic [RANK_W-1:0]  vic_rank_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;

    // Decision for the write-back pass
    logic             ins_reg;
    logic             evict_reg;
    logic [IDX_W-1:0] slot_reg;

    // Result waiting for the output register
    logic                  res_hit_reg;
    logic [VALUE_W-1:0]    res_value_reg;
    logic                  res_evicted_reg;
    logic [KEY_PORT_W-1:0] res_evkey_reg;

    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    logic       in_beat;
    logic       scan_phase;
    logic       upd_phase;
    logic       out_load;
    logic       ram_re;
    logic       ram_we;
    logic [ENT_W-1:0] ram_rdata;
    entry_t     rd_ent;
    entry_t     wr_ent;
    logic       scan_better;
    logic       dec_evict;
    logic       dec_ins;
    logic [IDX_W-1:0] dec_slot;
    logic       dec_slot_ok;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign scan_phase    = (state_reg == ST_SCAN) || (state_reg == ST_DRAIN);
    assign upd_phase     = (state_reg == ST_UPDATE) || (state_reg == ST_UPD_DRAIN);
    assign out_load      = (state_reg == ST_FINISH) && (!m_valid_reg || m_axis_tready);
    assign ram_re        = (state_reg == ST_SCAN) || (state_reg == ST_UPDATE);
    assign rd_ent        = entry_t'(ram_rdata);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_comb
    begin
        if (32'(cap_reg) > CAP)
        begin
            cap_eff = OCC_W'(CAP);
        end
        else
        begin
            cap_eff = OCC_W'(cap_reg);
        end
    end

    // Victim order: lowest use count first, then the least recent entry.
    assign scan_better = !vic_found_reg || (rd_ent.cnt < vic_cnt_reg) ||
                         ((rd_ent.cnt == vic_cnt_reg) && (rd_ent.rank > vic_rank_reg));

    always_comb
    begin
        dec_evict = op_put_reg && !hit_found_reg && (occ_reg >= cap_eff) && vic_found_reg;
        if (dec_evict)
        begin
            dec_slot_ok = 1'b1;
            if (free_found_reg && (free_idx_reg < vic_idx_reg))
            begin
                dec_slot = free_idx_reg;
            end
            else
            begin
                dec_slot = vic_idx_reg;
            end
        end
        else
        begin
            dec_slot_ok = free_found_reg;
            dec_slot    = free_idx_reg;
        end
        dec_ins = op_put_reg && !hit_found_reg && dec_slot_ok;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if ((state_reg == ST_DECIDE) && !hit_found_reg)
        begin
            if (dec_evict)
            begin
                valid_next[vic_idx_reg] = 1'b0;
            end
            if (dec_ins)
            begin
                valid_next[dec_slot] = 1'b1;
            end
        end
    end

    // Write-back data for the entry whose read data is arriving.
    always_comb
    begin
        wr_ent = rd_ent;
        if (ins_reg)
        begin
            if (pend_idx_reg == slot_reg)
            begin
                wr_ent.key   = op_key_reg;
                wr_ent.value = op_value_reg;
                wr_ent.cnt   = CNT_W'(1);
                wr_ent.rank  = '0;
            end
            else
            begin
                // Close the gap left by the victim, then age behind the new entry.
                if (evict_reg && (rd_ent.rank > vic_rank_reg))
                begin
                    wr_ent.rank = rd_ent.rank;
                end
                else
                begin
                    wr_ent.rank = rd_ent.rank + RANK_W'(1);
                end
            end
        end
        else
        begin
            if (pend_idx_reg == hit_idx_reg)
            begin
                wr_ent.value = op_put_reg ? op_value_reg : rd_ent.value;
                if (rd_ent.cnt < FREQ_TOP)
                begin
                    wr_ent.cnt = rd_ent.cnt + CNT_W'(1);
                end
                wr_ent.rank = '0;
            end
            else if (rd_ent.rank < hit_rank_reg)
            begin
                wr_ent.rank = rd_ent.rank + RANK_W'(1);
            end
        end
    end

    assign ram_we = pend_reg && upd_phase && valid_reg[pend_idx_reg];

    lfu_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAP)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pend_idx_reg),
        .wdata (wr_ent),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (in_beat)
                begin
                    state_next = (cap_eff == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                idx_next = '0;
                if (hit_found_reg || dec_ins)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_UPDATE:
            begin
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_LAST)
                begin
                    state_next = ST_UPD_DRAIN;
                end
            end
            ST_UPD_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            cap_reg     <= CAP_RESET;
            occ_reg     <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= ram_re;
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if ((state_reg == ST_DECIDE) && !hit_found_reg)
            begin
                occ_reg <= occ_reg - OCC_W'(dec_evict) + OCC_W'(dec_ins);
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and per-operation bookkeeping
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= idx_reg;
        if (in_beat)
        begin
            op_put_reg      <= s_axis_tuser;
            op_key_reg      <= s_axis_tdata[KEY_W-1:0];
            op_value_reg    <= s_axis_tdata[KEY_PORT_W +: VALUE_W];
            hit_found_reg   <= 1'b0;
            vic_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
            res_hit_reg     <= 1'b0;
            res_value_reg   <= '0;
            res_evicted_reg <= 1'b0;
            res_evkey_reg   <= '0;
        end
        if (pend_reg && scan_phase)
        begin
            if (valid_reg[pend_idx_reg])
            begin
                if (!hit_found_reg && (rd_ent.key == op_key_reg))
                begin
                    hit_found_reg <= 1'b1;
                    hit_idx_reg   <= pend_idx_reg;
                    hit_value_reg <= rd_ent.value;
                    hit_rank_reg  <= rd_ent.rank;
                end
                if (scan_better)
                begin
                    vic_found_reg <= 1'b1;
                    vic_idx_reg   <= pend_idx_reg;
                    vic_key_reg   <= rd_ent.key;
                    vic_cnt_reg   <= rd_ent.cnt;
                    vic_rank_reg  <= rd_ent.rank;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= pend_idx_reg;
            end
        end
        if (state_reg == ST_DECIDE)
        begin
            ins_reg         <= dec_ins;
            evict_reg       <= dec_evict;
            slot_reg        <= dec_slot;
            res_hit_reg     <= hit_found_reg;
            res_value_reg   <= (hit_found_reg && !op_put_reg) ? hit_value_reg : '0;
            res_evicted_reg <= dec_evict;
            res_evkey_reg   <= dec_evict ? KEY_PORT_W'(vic_key_reg) : '0;
        end
        if (out_load)
        begin
            m_data_reg <= {6'b0, res_evkey_reg, res_evicted_reg, res_value_reg, res_hit_reg};
        end
    end

endmodule

`default_nettype wire

// File: test/lfu_checker.sv
// ----------------------------------------------------------------------------
// lfu_checker: scoreboard for the LFU key-value store
// Watches the request, result and capacity channels. It keeps its own model
// of the store and compares every result beat, field by field, against the
// oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package lfu_tb_pkg;

    localparam int STORE_DEPTH = 16;
    localparam int USE_LIMIT   = 255;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    // Same layout as the result tdata: hit sits in bit 0.
    typedef struct packed {
        logic [15:0] evicted_key;
        logic        evicted;
        logic [31:0] read_value;
        logic        hit;
    } lookup_result_t;

endpackage

module lfu_checker
    import lfu_tb_pkg::*;
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    input  wire logic                               s_axis_tready,
    input  wire logic [lfu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  wire logic                               s_axis_tuser,
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic [lfu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [lfu_pkg::CAP_REG_W-1:0]      cfg_wdata,
    output int                                      mismatches,
    output int                                      outstanding
);

    logic                             slot_used [STORE_DEPTH];
    logic [15:0]                      slot_key  [STORE_DEPTH];
    logic [31:0]                      slot_val  [STORE_DEPTH];
    int unsigned                      slot_uses [STORE_DEPTH];
    int unsigned                      slot_age  [STORE_DEPTH];
    int unsigned                      fill;
    logic [lfu_pkg::CAP_REG_W-1:0]    capacity;
    lookup_result_t                   pending_results [$];

    // Applies one request to the model and returns the result it must produce.
    function automatic lookup_result_t apply_request(op_t op, logic [15:0] k, logic [31:0] v);
        lookup_result_t res;
        int unsigned    lim;
        int             found;
        int             victim;
        int             free_slot;
        res = '0;
        lim = (capacity > STORE_DEPTH) ? STORE_DEPTH : capacity;
        if (lim == 0)
            return res;
        found = -1;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (found < 0 && slot_used[i] && slot_key[i] == k)
                found = i;
        end
        if (found >= 0)
        begin
            res.hit = 1'b1;
            if (op == OP_GET)
                res.read_value = slot_val[found];
            else
                slot_val[found] = v;
            if (slot_uses[found] < USE_LIMIT)
                slot_uses[found]++;
            // Entries more recent than the touched one age by one.
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                if (slot_used[i] && i != found && slot_age[i] < slot_age[found])
                    slot_age[i]++;
            end
            slot_age[found] = 0;
            return res;
        end
        if (op == OP_GET)
            return res;
        if (fill >= lim)
        begin
            victim = -1;
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                if (slot_used[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                    (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim])))
                    victim = i;
            end
            if (victim >= 0)
            begin
                res.evicted     = 1'b1;
                res.evicted_key = slot_key[victim];
                slot_used[victim] = 1'b0;
                for (int i = 0; i < STORE_DEPTH; i++)
                begin
                    if (slot_used[i] && slot_age[i] > slot_age[victim])
                        slot_age[i]--;
                end
                if (fill > 0)
                    fill--;
            end
        end
        free_slot = -1;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (free_slot < 0 && !slot_used[i])
                free_slot = i;
        end
        if (free_slot < 0)
            return res;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (slot_used[i])
                slot_age[i]++;
        end
        slot_used[free_slot] = 1'b1;
        slot_key[free_slot]  = k;
        slot_val[free_slot]  = v;
        slot_uses[free_slot] = 1;
        slot_age[free_slot]  = 0;
        fill++;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        lookup_result_t want;
        lookup_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                slot_used[i] = 1'b0;
                slot_key[i]  = '0;
                slot_val[i]  = '0;
                slot_uses[i] = 0;
                slot_age[i]  = 0;
            end
            fill     = 0;
            capacity = lfu_pkg::CAP_RESET;
            pending_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // A result leaving now always belongs to an earlier request.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = lookup_result_t'(m_axis_tdata[$bits(lookup_result_t)-1:0]);
                if (pending_results.size() == 0)
                begin
                    $error("result beat with no request pending: %h", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, got.hit);
                        mismatches++;
                    end
                    if (got.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(want.read_value), $signed(got.read_value));
                        mismatches++;
                    end
                    if (got.evicted !== want.evicted)
                    begin
                        $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                        mismatches++;
                    end
                    if (got.evicted_key !== want.evicted_key)
                    begin
                        $error("evicted_key: expected 0x%h, got 0x%h",
                               want.evicted_key, got.evicted_key);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
                capacity = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(apply_request(op_t'(s_axis_tuser),
                                                        s_axis_tdata[15:0],
                                                        s_axis_tdata[47:16]));
            outstanding = pending_results.size();
        end
    end

endmodule

// File: test/tb_lfu_cache_lru_tiebreak_top.sv
// ----------------------------------------------------------------------------
// tb_lfu_cache_lru_tiebreak_top: testbench for the LFU key-value store
// Drives get and put requests in bursts while the result side stalls on its
// own pattern, and steps the capacity through zero, small, full and
// oversized settings. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lfu_cache_lru_tiebreak_top;

    import lfu_tb_pkg::*;

    localparam int QUIET_LIMIT = 3000;

    logic                               clk;
    logic                               rst_n          = 1'b0;
    logic                               s_axis_tvalid  = 1'b0;
    logic                               s_axis_tready;
    logic [lfu_pkg::IN_TDATA_W-1:0]     s_axis_tdata   = '0;
    logic                               s_axis_tuser   = 1'b0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready  = 1'b0;
    logic [lfu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                               cfg_we         = 1'b0;
    logic [lfu_pkg::CAP_REG_W-1:0]      cfg_wdata      = '0;

    int mismatches;
    int outstanding;
    int burst_left  = 0;
    int quiet_cycles = 0;

    lfu_cache_lru_tiebreak_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    lfu_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result side: alternates between always ready, random ready and long stalls.
    initial
    begin : result_stall
        int mode;
        int span;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(5, 80);
            if (mode == 2)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 60)) @(posedge clk);
            end
            else
            begin
                repeat (span)
                begin
                    m_axis_tready <= (mode == 0) ? 1'b1 : 1'($urandom_range(0, 1));
                    @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Presents one request beat and returns at the edge where it is taken.
    task automatic send_request(input op_t op, input logic [15:0] k, input logic [31:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, k};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Holds off the sender until every pending result has been taken.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_capacity(input logic [lfu_pkg::CAP_REG_W-1:0] cap);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random traffic over a small key pool, with a hot key and stray keys.
    task automatic run_traffic(input logic [lfu_pkg::CAP_REG_W-1:0] cap, input int count,
                               input int pool_size, input int hot_pct, input int put_pct);
        logic [15:0] pool [32];
        logic [15:0] k;
        int          pick;
        op_t         op;
        set_capacity(cap);
        for (int i = 0; i < pool_size; i++)
            pool[i] = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 1) == 1)
            pool[pool_size - 1] = 16'hFFFF;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < hot_pct)
                k = pool[0];
            else if (pick < 95)
                k = pool[$urandom_range(0, pool_size - 1)];
            else
                k = 16'($urandom_range(0, 65535));
            op = ($urandom_range(0, 99) < put_pct) ? OP_PUT : OP_GET;
            send_request(op, k, $urandom);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting from the reset capacity.
        send_request(OP_GET, 16'h0000, 32'h0000_0000);
        send_request(OP_PUT, 16'h0000, 32'h7FFF_FFFF);
        send_request(OP_PUT, 16'hFFFF, 32'h8000_0000);
        send_request(OP_GET, 16'hFFFF, 32'h1234_5678);
        send_request(OP_PUT, 16'h0000, 32'hFFFF_FFFF);
        send_request(OP_GET, 16'h0000, 32'h0000_0000);
        send_request(OP_GET, 16'h1234, 32'h0000_0000);
        send_request(OP_PUT, 16'h5555, 32'hAAAA_AAAA);
        send_request(OP_PUT, 16'hAAAA, 32'h5555_5555);
        // Capacity below occupancy: each new key evicts exactly one entry.
        set_capacity(5'd2);
        send_request(OP_PUT, 16'h0001, 32'h0000_0001);
        send_request(OP_PUT, 16'h0002, 32'h0000_0002);
        send_request(OP_GET, 16'h0001, 32'h0000_0000);
        // A disabled store misses even on keys it still holds.
        set_capacity(5'd0);
        send_request(OP_GET, 16'h0000, 32'h0000_0000);
        send_request(OP_PUT, 16'h7777, 32'h0BAD_F00D);
        set_capacity(5'd31);
        send_request(OP_GET, 16'h0000, 32'h0000_0000);
        send_request(OP_PUT, 16'h7777, 32'h0BAD_F00D);
        send_request(OP_GET, 16'h7777, 32'h0000_0000);
        set_capacity(5'd1);
        send_request(OP_PUT, 16'h0003, 32'h8000_0001);
        send_request(OP_GET, 16'h0003, 32'h0000_0000);
        send_request(OP_PUT, 16'h0004, 32'h7FFF_FFFE);

        run_traffic(5'd16, 100, 24, 0, 50);
        run_traffic(5'd1, 60, 3, 0, 50);
        run_traffic(5'd0, 30, 8, 0, 50);
        run_traffic(5'd31, 50, 20, 0, 50);
        run_traffic(5'd5, 100, 8, 0, 50);
        // One hot key drives its use count into saturation.
        run_traffic(5'd2, 330, 6, 85, 30);
        run_traffic(5'd16, 60, 20, 0, 70);
        run_traffic(5'd3, 100, 10, 0, 60);
        run_traffic(5'd17, 50, 30, 0, 50);

        drain_results();
        repeat (60) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/lfu_pkg.sv
rtl/lfu_ram.sv
rtl/lfu_cache_lru_tiebreak_top.sv
test/lfu_checker.sv
test/tb_lfu_cache_lru_tiebreak_top.sv
